>>> rtl/core/sbs_pkg.sv
// ----------------------------------------------------------------------------
// Signature scanner package
// Sizes, item codes and shared types of the multi-signature byte scanner.
// ----------------------------------------------------------------------------
package sbs_pkg;

  localparam int NUM_SIGS     = 8;
  localparam int MAX_SIG_LEN  = 32;
  localparam int MAX_SCAN     = 65536;
  localparam int REPORT_SLOTS = (NUM_SIGS < 8) ? NUM_SIGS : 8;

  localparam int SLOT_W  = (NUM_SIGS > 1) ? $clog2(NUM_SIGS) : 1;
  localparam int POS_W   = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;
  localparam int LEN_W   = $clog2(MAX_SIG_LEN + 1);
  localparam int SEEN_W  = $clog2(MAX_SCAN + 1);
  localparam int OFF_W   = 16;
  localparam int CMP_W   = (SEEN_W > LEN_W) ? ((SEEN_W > OFF_W) ? SEEN_W : OFF_W)
                                            : ((LEN_W > OFF_W) ? LEN_W : OFF_W);
  localparam int REP_IDX_W = (REPORT_SLOTS > 1) ? $clog2(REPORT_SLOTS) : 1;
  localparam int REP_CNT_W = $clog2(REPORT_SLOTS + 1);

  localparam int MODE_W     = 2;
  localparam int SLOT_IN_W  = 3;
  localparam int POS_IN_W   = 5;
  localparam int BYTE_W     = 8;
  localparam int LEN_IN_W   = 6;
  localparam int LEN_OUT_W  = 6;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_SCAN = 2'd1,
    MODE_END  = 2'd2
  } mode_e;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
  } sig_wr_t;

endpackage

>>> rtl/core/sbs_sig_table.sv
// ----------------------------------------------------------------------------
// Signature table
// Holds the loaded signature bytes and lengths, and on every load produces
// the slot's signature reversed and aligned to the newest window byte.
// ----------------------------------------------------------------------------
module sbs_sig_table (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                load_i,
  input  logic [sbs_pkg::SLOT_IN_W-1:0]                       slot_i,
  input  logic [sbs_pkg::POS_IN_W-1:0]                        byte_pos_i,
  input  logic [sbs_pkg::BYTE_W-1:0]                          data_byte_i,
  input  logic [sbs_pkg::LEN_IN_W-1:0]                        sig_length_i,
  output sbs_pkg::sig_wr_t                                    wr_o,
  output logic [sbs_pkg::MAX_SIG_LEN-1:0][sbs_pkg::BYTE_W-1:0] rev_row_o,
  output logic [sbs_pkg::MAX_SIG_LEN-1:0]                     care_o,
  output logic [sbs_pkg::NUM_SIGS-1:0][sbs_pkg::LEN_W-1:0]    len_o
);
  import sbs_pkg::*;

  logic [MAX_SIG_LEN-1:0][BYTE_W-1:0] row_q [NUM_SIGS];
  logic [NUM_SIGS-1:0][LEN_W-1:0]     len_q;
  logic [MAX_SIG_LEN-1:0][BYTE_W-1:0] new_row;
  logic [MAX_SIG_LEN-1:0][BYTE_W-1:0] rev_full;
  logic [LEN_W-1:0]                   len_clamp;
  logic [LEN_W-1:0]                   shift_amt;
  logic                               slot_ok;
  logic                               pos_ok;

  assign slot_ok   = 32'(slot_i) < NUM_SIGS;
  assign pos_ok    = 32'(byte_pos_i) < MAX_SIG_LEN;
  assign len_clamp = (32'(sig_length_i) > MAX_SIG_LEN) ? LEN_W'(MAX_SIG_LEN)
                                                        : LEN_W'(sig_length_i);

  assign wr_o.we   = load_i && slot_ok;
  assign wr_o.slot = SLOT_W'(slot_i);

  always_comb begin
    new_row = row_q[wr_o.slot];
    if (pos_ok) begin
      new_row[POS_W'(byte_pos_i)] = data_byte_i;
    end
    for (int j = 0; j < MAX_SIG_LEN; j++) begin
      rev_full[j] = new_row[MAX_SIG_LEN-1-j];
    end
  end

  // Window cell m compares against signature byte (length - 1 - m).
  assign shift_amt = LEN_W'(MAX_SIG_LEN) - len_clamp;
  assign rev_row_o = rev_full >> {shift_amt, 3'b000};
  assign care_o    = ~({MAX_SIG_LEN{1'b1}} << len_clamp);
  assign len_o     = len_q;

  always_ff @(posedge clk_i) begin
    if (wr_o.we) begin
      row_q[wr_o.slot] <= new_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (wr_o.we) begin
      len_q[wr_o.slot] <= len_clamp;
    end
  end

endmodule

>>> rtl/core/sbs_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds one byte of the scan window and the matching signature byte of every
// slot, passes its byte to the next cell on each scan, and flags hits.
// ----------------------------------------------------------------------------
module sbs_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         shift_i,
  input  logic [sbs_pkg::BYTE_W-1:0]   byte_i,
  output logic [sbs_pkg::BYTE_W-1:0]   byte_o,
  input  sbs_pkg::sig_wr_t             wr_i,
  input  logic [sbs_pkg::BYTE_W-1:0]   wr_byte_i,
  input  logic                         wr_care_i,
  output logic [sbs_pkg::NUM_SIGS-1:0] hit_o
);
  import sbs_pkg::*;

  logic [BYTE_W-1:0]                win_q;
  logic [NUM_SIGS-1:0][BYTE_W-1:0]  sig_q;
  logic [NUM_SIGS-1:0]              care_q;

  assign byte_o = win_q;

  always_comb begin
    for (int s = 0; s < NUM_SIGS; s++) begin
      hit_o[s] = !care_q[s] || (byte_i == sig_q[s]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      win_q <= byte_i;
    end
    if (wr_i.we) begin
      sig_q[wr_i.slot] <= wr_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      care_q <= '0;
    end else if (wr_i.we) begin
      care_q[wr_i.slot] <= wr_care_i;
    end
  end

endmodule

>>> rtl/core/sbs_report.sv
// ----------------------------------------------------------------------------
// Report sequencer
// Captures the scan results at end of buffer and hands them out one word
// per slot, in slot order, marking the final word.
// ----------------------------------------------------------------------------
module sbs_report (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   start_i,
  input  logic [sbs_pkg::REPORT_SLOTS-1:0]                       found_i,
  input  logic [sbs_pkg::REPORT_SLOTS-1:0][sbs_pkg::OFF_W-1:0]   off_i,
  input  logic [sbs_pkg::REPORT_SLOTS-1:0][sbs_pkg::LEN_W-1:0]   len_i,
  output logic                                                   can_start_o,
  output logic                                                   out_valid_o,
  input  logic                                                   out_stall_i,
  output logic [sbs_pkg::SLOT_IN_W-1:0]                          sig_slot_o,
  output logic                                                   found_o,
  output logic [sbs_pkg::OFF_W-1:0]                              start_offset_o,
  output logic [sbs_pkg::LEN_OUT_W-1:0]                          match_length_o,
  output logic                                                   last_o
);
  import sbs_pkg::*;

  logic                                       active_q, active_d;
  logic [REP_IDX_W-1:0]                       idx_q, idx_d;
  logic [REP_IDX_W-1:0]                       last_idx_q, last_idx_d;
  logic [REPORT_SLOTS-1:0]                    fnd_q;
  logic [REPORT_SLOTS-1:0][OFF_W-1:0]         off_q;
  logic [REPORT_SLOTS-1:0][LEN_W-1:0]         len_q;
  logic [REP_CNT_W-1:0]                       count;
  logic                                       take;
  logic                                       at_last;

  // The report ends at the first empty slot.
  always_comb begin
    logic stop;
    stop  = 1'b0;
    count = '0;
    for (int r = 0; r < REPORT_SLOTS; r++) begin
      if (!stop && (len_i[r] != '0)) begin
        count = REP_CNT_W'(r + 1);
      end else begin
        stop = 1'b1;
      end
    end
  end

  assign take        = active_q && !out_stall_i;
  assign at_last     = idx_q == last_idx_q;
  assign can_start_o = !active_q || (take && at_last);

  always_comb begin
    active_d   = active_q;
    idx_d      = idx_q;
    last_idx_d = last_idx_q;
    priority if (start_i) begin
      active_d   = count != '0;
      idx_d      = '0;
      last_idx_d = REP_IDX_W'(count - 1'b1);
    end else if (take) begin
      if (at_last) begin
        active_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      idx_q      <= '0;
      last_idx_q <= '0;
    end else begin
      active_q   <= active_d;
      idx_q      <= idx_d;
      last_idx_q <= last_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      fnd_q <= found_i;
      len_q <= len_i;
      for (int r = 0; r < REPORT_SLOTS; r++) begin
        off_q[r] <= found_i[r] ? off_i[r] : '0;
      end
    end
  end

  assign out_valid_o    = active_q;
  assign sig_slot_o     = SLOT_IN_W'(idx_q);
  assign found_o        = fnd_q[idx_q];
  assign start_offset_o = off_q[idx_q];
  assign match_length_o = LEN_OUT_W'(len_q[idx_q]);
  assign last_o         = at_last;

endmodule

>>> rtl/core/multi_signature_byte_scanner_core.sv
// ----------------------------------------------------------------------------
// Multi-signature byte scanner
// Matches a byte stream against a table of signatures and reports, per slot,
// whether each signature occurred and the offset of its first occurrence.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Word
//  in      | input     | in_valid_i/in_stall_o | mode, slot, byte_pos, data_byte, sig_length
//  out     | output    | out_valid_o/out_stall_i | sig_slot, found, start_offset, match_length, last
//
//  Load and scan words are taken one per cycle; each scan byte is compared
//  against every signature across the window cells in the cycle it arrives.
//  An end word starts a report of one output word per cycle per slot up to
//  the first empty slot; a further end word waits until the previous report's
//  final word is taken. Reset needs no clearing pass; words are taken from the
//  first cycle. A stalled output holds its word while scan and load words flow.
// ----------------------------------------------------------------------------
module multi_signature_byte_scanner_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sbs_pkg::MODE_W-1:0]      mode_i,
  input  logic [sbs_pkg::SLOT_IN_W-1:0]   slot_i,
  input  logic [sbs_pkg::POS_IN_W-1:0]    byte_pos_i,
  input  logic [sbs_pkg::BYTE_W-1:0]      data_byte_i,
  input  logic [sbs_pkg::LEN_IN_W-1:0]    sig_length_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sbs_pkg::SLOT_IN_W-1:0]   sig_slot_o,
  output logic                            found_o,
  output logic [sbs_pkg::OFF_W-1:0]       start_offset_o,
  output logic [sbs_pkg::LEN_OUT_W-1:0]   match_length_o,
  output logic                            last_o
);
  import sbs_pkg::*;

  logic                                      in_acc;
  logic                                      load_go;
  logic                                      scan_go;
  logic                                      end_go;
  logic                                      can_start;
  sig_wr_t                                   wr;
  logic [MAX_SIG_LEN-1:0][BYTE_W-1:0]        rev_row;
  logic [MAX_SIG_LEN-1:0]                    care;
  logic [NUM_SIGS-1:0][LEN_W-1:0]            len;
  logic [MAX_SIG_LEN:0][BYTE_W-1:0]          chain;
  logic [MAX_SIG_LEN-1:0][NUM_SIGS-1:0]      hit;
  logic [NUM_SIGS-1:0]                       all_hit;
  logic [SEEN_W-1:0]                         seen_q, seen_d, seen_inc;
  logic [NUM_SIGS-1:0]                       found_q, found_d;
  logic [NUM_SIGS-1:0][OFF_W-1:0]            off_q, off_d;
  logic [NUM_SIGS-1:0]                       new_hit;

  assign in_stall_o = (mode_i == MODE_END) && !can_start;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_go    = in_acc && (mode_i == MODE_LOAD);
  assign scan_go    = in_acc && (mode_i == MODE_SCAN) && (32'(seen_q) < MAX_SCAN);
  assign end_go     = in_acc && (mode_i == MODE_END);

  sbs_sig_table u_sig_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load_go),
    .slot_i       (slot_i),
    .byte_pos_i   (byte_pos_i),
    .data_byte_i  (data_byte_i),
    .sig_length_i (sig_length_i),
    .wr_o         (wr),
    .rev_row_o    (rev_row),
    .care_o       (care),
    .len_o        (len)
  );

  assign chain[0] = data_byte_i;

  for (genvar m = 0; m < MAX_SIG_LEN; m++) begin : g_cell
    sbs_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (scan_go),
      .byte_i    (chain[m]),
      .byte_o    (chain[m+1]),
      .wr_i      (wr),
      .wr_byte_i (rev_row[m]),
      .wr_care_i (care[m]),
      .hit_o     (hit[m])
    );
  end

  always_comb begin
    all_hit = '1;
    for (int m = 0; m < MAX_SIG_LEN; m++) begin
      all_hit = all_hit & hit[m];
    end
  end

  assign seen_inc = seen_q + 1'b1;

  always_comb begin
    found_d = found_q;
    off_d   = off_q;
    seen_d  = seen_q;
    for (int s = 0; s < NUM_SIGS; s++) begin
      new_hit[s] = (len[s] != '0) && !found_q[s] &&
                   (CMP_W'(seen_inc) >= CMP_W'(len[s])) && all_hit[s];
    end
    priority if (end_go) begin
      found_d = '0;
      seen_d  = '0;
    end else if (scan_go) begin
      seen_d = seen_inc;
      for (int s = 0; s < NUM_SIGS; s++) begin
        if (new_hit[s]) begin
          found_d[s] = 1'b1;
          off_d[s]   = OFF_W'(CMP_W'(seen_inc) - CMP_W'(len[s]));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= '0;
      seen_q  <= '0;
    end else begin
      found_q <= found_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
  end

  sbs_report u_report (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (end_go),
    .found_i        (found_q[REPORT_SLOTS-1:0]),
    .off_i          (off_q[REPORT_SLOTS-1:0]),
    .len_i          (len[REPORT_SLOTS-1:0]),
    .can_start_o    (can_start),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sig_slot_o     (sig_slot_o),
    .found_o        (found_o),
    .start_offset_o (start_offset_o),
    .match_length_o (match_length_o),
    .last_o         (last_o)
  );

endmodule

>>> rtl/core/sbs_checker.sv
// ----------------------------------------------------------------------------
// Scanner port checker
// Watches the scanner's ports for report ordering and output word rules.
// ----------------------------------------------------------------------------
module sbs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [sbs_pkg::MODE_W-1:0]      mode_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [sbs_pkg::SLOT_IN_W-1:0]   sig_slot_o,
  input logic                            found_o,
  input logic [sbs_pkg::OFF_W-1:0]       start_offset_o,
  input logic                            last_o
);
  import sbs_pkg::*;

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sig_slot_o) &&
      $stable(start_offset_o) && $stable(last_o))
    else $error("Stalled output word changed.");

  a_slot_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      out_valid_o && (sig_slot_o == $past(sig_slot_o) + 3'd1))
    else $error("Report did not continue with the next slot.");

  a_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o |=> !out_valid_o || (sig_slot_o == 3'd0))
    else $error("New report did not start at slot zero.");

  a_offset_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> start_offset_o == 16'd0)
    else $error("Offset reported for a signature that was not found.");

  a_after_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && (mode_i == MODE_END)))
    else $error("Report started without an end-of-buffer word.");

endmodule

bind multi_signature_byte_scanner_core sbs_checker u_sbs_checker (.*);
